// ===== rtl/core/largest_prime_divisor_assert.svh =====
`ifndef LARGEST_PRIME_DIVISOR_ASSERT_SVH
`define LARGEST_PRIME_DIVISOR_ASSERT_SVH

// Concurrent check on clk_i, switched off while rst_ni is low.
`define LPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define LPD_ASSERT_IMP(lbl, ante, cons, msg) \
  `LPD_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/lpd_pkg.sv =====
package lpd_pkg;

  localparam int unsigned VALUE_W      = 32;  // input word and magnitude
  localparam int unsigned PRIME_W      = 31;  // result field
  localparam int unsigned OUT_DATA_W   = 32;  // result field padded to bytes
  localparam int unsigned DIV_W        = 17;  // trial divisor, odd and <= 46343
  localparam int unsigned DSQ_W        = 34;  // square of the trial divisor
  localparam int unsigned MAG_BITS_DEF = 31;
  localparam int unsigned PC_W         = 4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_HALVE,
    OP_DIV_GO,
    OP_TAKE,
    OP_NEXT_D,
    OP_BEST_N,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_FALL,
    C_ALWAYS,
    C_N_LT2,
    C_N_ODD,
    C_DSQ_GT_N,
    C_REM_NZ,
    C_WAIT_IN,
    C_WAIT_DIV,
    C_WAIT_OUT
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] S_TINY  = 4'd1;
  localparam logic [PC_W-1:0] S_EVEN  = 4'd2;
  localparam logic [PC_W-1:0] S_HALVE = 4'd3;
  localparam logic [PC_W-1:0] S_LOOP  = 4'd4;
  localparam logic [PC_W-1:0] S_DIV   = 4'd5;
  localparam logic [PC_W-1:0] S_WAIT  = 4'd6;
  localparam logic [PC_W-1:0] S_TEST  = 4'd7;
  localparam logic [PC_W-1:0] S_TAKE  = 4'd8;
  localparam logic [PC_W-1:0] S_NEXT  = 4'd9;
  localparam logic [PC_W-1:0] S_TAIL  = 4'd10;
  localparam logic [PC_W-1:0] S_LAST  = 4'd11;
  localparam logic [PC_W-1:0] S_EMIT  = 4'd12;

  // Control store. A wait condition holds the step until it is met, then fires
  // the op and goes to the target; any other condition fires the op and jumps
  // to the target when true, else falls through to the next step.
  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    case (pc)
      S_IDLE:  cw = '{OP_LOAD,   C_WAIT_IN,  S_TINY};
      S_TINY:  cw = '{OP_NONE,   C_N_LT2,    S_EMIT};
      S_EVEN:  cw = '{OP_NONE,   C_N_ODD,    S_LOOP};
      S_HALVE: cw = '{OP_HALVE,  C_ALWAYS,   S_EVEN};
      S_LOOP:  cw = '{OP_NONE,   C_DSQ_GT_N, S_TAIL};
      S_DIV:   cw = '{OP_DIV_GO, C_FALL,     S_IDLE};
      S_WAIT:  cw = '{OP_NONE,   C_WAIT_DIV, S_TEST};
      S_TEST:  cw = '{OP_NONE,   C_REM_NZ,   S_NEXT};
      S_TAKE:  cw = '{OP_TAKE,   C_ALWAYS,   S_DIV};
      S_NEXT:  cw = '{OP_NEXT_D, C_ALWAYS,   S_LOOP};
      S_TAIL:  cw = '{OP_NONE,   C_N_LT2,    S_EMIT};
      S_LAST:  cw = '{OP_BEST_N, C_FALL,     S_IDLE};
      S_EMIT:  cw = '{OP_EMIT,   C_WAIT_OUT, S_IDLE};
      default: cw = '{OP_NONE,   C_ALWAYS,   S_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/core/lpd_div.sv =====
module lpd_div #(
  parameter int unsigned DIVIDEND_W = lpd_pkg::VALUE_W,
  parameter int unsigned DIVISOR_W  = lpd_pkg::DIV_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output lpd_pkg::div_stat_t    stat_o,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output logic [DIVISOR_W-1:0]  remainder_o
);
  import lpd_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dsr_q;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  // Restoring division, one quotient bit per cycle. The dividend shifts out of
  // the top of quo_q while quotient bits shift in at the bottom.
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
      rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign stat_o      = '{busy: busy_q, done: done_q};
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== rtl/core/largest_prime_divisor.sv =====
// Latency is data dependent: the word is taken, then each factor of two is halved out,
// then each odd trial divisor runs the 32-step bit-serial divider, where most of the time
// goes, once if it does not divide and once per factor taken out. The worst case is a prime
// magnitude close to 2^31. One word is worked on at a time; a new word is taken in the
// cycle after the result is registered.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops m_axis_tvalid.
module largest_prime_divisor #(
  parameter int unsigned MAG_BITS = lpd_pkg::MAG_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [lpd_pkg::VALUE_W-1:0]        s_axis_tdata,   // [31:0] value
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [lpd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // [30:0] largest_prime, [31] 0
  output logic                               m_axis_tuser    // [0] found
);
  import lpd_pkg::*;

  `include "largest_prime_divisor_assert.svh"

  localparam logic [PRIME_W-1:0] OUT_MASK = (MAG_BITS >= PRIME_W) ? {PRIME_W{1'b1}} :
                                            PRIME_W'((64'd1 << MAG_BITS) - 64'd1);

  logic [PC_W-1:0]      pc_q, pc_d;
  ctrl_word_t           cw;
  logic                 is_wait, wait_ok, take, fire;

  logic [VALUE_W-1:0]   n_q;
  logic [DIV_W-1:0]     d_q;
  logic [DSQ_W-1:0]     dsq_q;
  logic [PRIME_W-1:0]   best_q;
  logic [VALUE_W-1:0]   mag;

  logic                 out_valid_q;
  logic [PRIME_W-1:0]   out_prime_q;
  logic                 out_found_q;
  logic                 out_busy;

  div_stat_t            div_stat;
  logic                 div_start;
  logic [VALUE_W-1:0]   div_quo;
  logic [DIV_W-1:0]     div_rem;

  assign cw       = ucode(pc_q);
  assign out_busy = out_valid_q && !m_axis_tready;
  assign mag      = s_axis_tdata[VALUE_W-1] ? (VALUE_W'(0) - s_axis_tdata) : s_axis_tdata;

  always_comb begin
    is_wait = 1'b0;
    wait_ok = 1'b0;
    take    = 1'b0;
    case (cw.cond)
      C_FALL:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_N_LT2:    take = (n_q < VALUE_W'(2));
      C_N_ODD:    take = n_q[0];
      C_DSQ_GT_N: take = (dsq_q > DSQ_W'(n_q));
      C_REM_NZ:   take = (div_rem != '0);
      C_WAIT_IN: begin
        is_wait = 1'b1;
        wait_ok = s_axis_tvalid;
      end
      C_WAIT_DIV: begin
        is_wait = 1'b1;
        wait_ok = div_stat.done;
      end
      C_WAIT_OUT: begin
        is_wait = 1'b1;
        wait_ok = !out_busy;
      end
      default:    take = 1'b1;
    endcase
    fire = !is_wait || wait_ok;
    if (is_wait) begin
      pc_d = wait_ok ? cw.target : pc_q;
    end else begin
      pc_d = take ? cw.target : pc_q + PC_W'(1);
    end
  end

  assign s_axis_tready = (pc_q == S_IDLE);
  assign div_start     = fire && (cw.op == OP_DIV_GO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (fire && cw.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      case (cw.op)
        OP_LOAD: begin
          n_q    <= mag;
          best_q <= '0;
          d_q    <= DIV_W'(3);
          dsq_q  <= DSQ_W'(9);
        end
        OP_HALVE: begin
          n_q    <= {1'b0, n_q[VALUE_W-1:1]};
          best_q <= PRIME_W'(2);
        end
        OP_TAKE: begin
          n_q    <= div_quo;
          best_q <= PRIME_W'(d_q);
        end
        OP_NEXT_D: begin
          // (d + 2)^2 = d^2 + 4d + 4
          dsq_q <= dsq_q + DSQ_W'({d_q, 2'b00}) + DSQ_W'(4);
          d_q   <= d_q + DIV_W'(2);
        end
        OP_BEST_N: best_q <= n_q[PRIME_W-1:0];
        OP_EMIT: begin
          out_prime_q <= best_q & OUT_MASK;
          out_found_q <= (best_q != '0);
        end
        default: ;
      endcase
    end
  end

  lpd_div #(
    .DIVIDEND_W (VALUE_W),
    .DIVISOR_W  (DIV_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (n_q),
    .divisor_i   (d_q),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - PRIME_W){1'b0}}, out_prime_q};
  assign m_axis_tuser  = out_found_q;

  `LPD_ASSERT_IMP(a_div_start_idle, div_start, !div_stat.busy,
                  "divider started while busy")
  `LPD_ASSERT_IMP(a_trial_odd, pc_q != S_IDLE, d_q[0],
                  "trial divisor is even")
  `LPD_ASSERT_IMP(a_found_match, m_axis_tvalid, m_axis_tuser == (m_axis_tdata != '0),
                  "found flag disagrees with the prime")
  `LPD_ASSERT(a_done_waits, div_stat.done |-> (pc_q == S_WAIT),
              "divider finished outside the wait step")

endmodule

// ===== test/lpd_result_checker.sv =====
// Watches both stream channels of the largest prime divisor block, predicts the
// result of every accepted input word and compares it with the output words in order.
module lpd_result_checker #(
  parameter int unsigned MAG_BITS = lpd_pkg::MAG_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [lpd_pkg::VALUE_W-1:0]    s_axis_tdata,   // [31:0] value
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [lpd_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [30:0] largest_prime, [31] 0
  input  logic                           m_axis_tuser,   // [0] found
  output int                             fail_count_o,
  output int                             pending_o
);

  import lpd_pkg::*;

  typedef struct packed {
    logic [PRIME_W-1:0] prime;
    logic               found;
  } divisor_t;

  divisor_t expected_divisors[$];
  int       fails = 0;

  // Trial division on the exact magnitude; the most negative word becomes 2^31.
  function automatic divisor_t predict_largest_prime(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] mag;
    longint unsigned    n;
    longint unsigned    d;
    longint unsigned    best;
    divisor_t           r;
    mag  = value[VALUE_W-1] ? (~value + 1'b1) : value;
    n    = mag;
    best = 0;
    if (n >= 2) begin
      while ((n & 1) == 0) begin
        best = 2;
        n    = n >> 1;
      end
      d = 3;
      while (d * d <= n) begin
        while (n % d == 0) begin
          best = d;
          n    = n / d;
        end
        d = d + 2;
      end
      if (n > 1) begin
        best = n;
      end
    end
    r.found  = (best != 0);
    best     = best & ((64'd1 << MAG_BITS) - 1);
    r.prime  = best[PRIME_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin : watch
    divisor_t want;
    if (rst_ni) begin
      // Retire before queueing, so an output word can never match the input of its own edge.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_divisors.size() == 0) begin
          $display("%0t: output word %0d found=%0b arrived with no result expected",
                   $time, m_axis_tdata[PRIME_W-1:0], m_axis_tuser);
          fails++;
        end else begin
          want = expected_divisors.pop_front();
          if (m_axis_tdata[PRIME_W-1:0] !== want.prime) begin
            $display("%0t: largest_prime expected %0d, actual %0d",
                     $time, want.prime, m_axis_tdata[PRIME_W-1:0]);
            fails++;
          end
          if (m_axis_tuser !== want.found) begin
            $display("%0t: found expected %0b, actual %0b", $time, want.found, m_axis_tuser);
            fails++;
          end
          if (m_axis_tdata[OUT_DATA_W-1:PRIME_W] !== '0) begin
            $display("%0t: padding bits expected 0, actual %0h",
                     $time, m_axis_tdata[OUT_DATA_W-1:PRIME_W]);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_divisors.push_back(predict_largest_prime(s_axis_tdata));
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_divisors.size();
  end

endmodule

// ===== test/tb.sv =====
module tb;

  import lpd_pkg::*;

  // A prime magnitude near 2^31 keeps the block busy longest.
  localparam int unsigned STALL_LIMIT  = 3_000_000;
  localparam int          RANDOM_WORDS = 76;
  localparam int          DRAIN_CYCLES = 64;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [VALUE_W-1:0]    s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  int          fail_count;
  int          pending;
  int unsigned idle_cycles = 0;
  bit          steady_in   = 1'b0;
  bit          steady_out  = 1'b0;

  largest_prime_divisor u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  lpd_result_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offers one input word after a random gap and returns at the edge that accepts it.
  task automatic send_value(input logic [VALUE_W-1:0] value);
    int gap;
    if ($urandom_range(0, 15) == 0) begin
      steady_in = ~steady_in;
    end
    gap = steady_in ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Result side: either holds tready low while a word waits, or raises it early.
  initial begin : sink
    int gap;
    m_axis_tready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) begin
        steady_out = ~steady_out;
      end
      gap = steady_out ? 0 : $urandom_range(0, 7);
      if (!steady_out && $urandom_range(0, 1) == 1) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
        while (!m_axis_tvalid) @(posedge clk_i);
        repeat (gap) @(posedge clk_i);
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
        while (!m_axis_tvalid) @(posedge clk_i);
      end
    end
  end

  initial begin : source
    logic [VALUE_W-1:0] value;
    int                 kind;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero and magnitude one report no prime, minus one included; small values follow.
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);
    send_value(32'd2);
    send_value(32'd3);
    send_value(32'd4);
    send_value(32'hFFFF_FFFE);
    // Squares of primes sit right on the end test of the trial loop; composites follow.
    send_value(32'd9);
    send_value(32'd25);
    send_value(32'd49);
    send_value(32'd961);
    send_value(32'd15);
    send_value(32'd1024);
    send_value(32'd30030);
    // The most negative word has magnitude 2^31.
    send_value(32'h8000_0000);
    send_value(32'h4000_0000);
    // Largest positive word, itself prime: the longest search of the run.
    send_value(32'h7FFF_FFFF);
    send_value(32'h4000_4000);
    send_value(32'h5555_5555);
    send_value(32'hAAAA_AAAB);
    send_value(32'd1162261467);
    send_value(-32'd1162261467);
    send_value(32'd131042);
    send_value(32'h7FFF_0000);

    // Random words are kept to small or smooth magnitudes so the search stays short.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        value = $urandom & ((32'd1 << $urandom_range(1, 14)) - 1);
      end else if (kind < 8) begin
        value = 32'($urandom_range(1, 16383)) << $urandom_range(0, 17);
      end else begin
        value = $urandom & 32'h0003_FFFF;
      end
      if ($urandom_range(0, 2) == 0) begin
        value = -value;
      end
      send_value(value);
    end
    s_axis_tvalid <= 1'b0;

    // The pending count is registered, so the check waits until it includes the last word.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lpd_pkg.sv
rtl/core/lpd_div.sv
rtl/core/largest_prime_divisor.sv
test/lpd_result_checker.sv
test/tb.sv
